/* src/ddsp_pkg.sv */
// ----------------------------------------------------------------------------
// ddsp_pkg: shared types and constants
// State codes, item modes and the node limit of the engine.
// ----------------------------------------------------------------------------
package ddsp_pkg;

   localparam int MAX_NODES = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_WALK,
      ST_EMIT,
      ST_FAIL
   } state_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

/* src/ddsp_cell.sv */
// ----------------------------------------------------------------------------
// ddsp_cell: one node cell of the chain
// Holds dist, reached, visited and pred of one node. Relax commands flow
// through the chain one cell per cycle; the cell merges itself into the
// running minimum when the scan reaches it.
// ----------------------------------------------------------------------------
module ddsp_cell #(
   parameter int IDX_BITS  = 4,
   parameter int DIST_BITS = 24,
   parameter int MY_INDEX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 init,
   input  logic                 init_src,
   // relax command from the left neighbor
   input  logic                 rl_valid,
   input  logic [IDX_BITS-1:0]  rl_target,
   input  logic [DIST_BITS-1:0] rl_cand,
   input  logic [IDX_BITS-1:0]  rl_from,
   input  logic                 rl_edge,
   output logic                 rr_valid,
   output logic [IDX_BITS-1:0]  rr_target,
   output logic [DIST_BITS-1:0] rr_cand,
   output logic [IDX_BITS-1:0]  rr_from,
   output logic                 rr_edge,
   // minimum scan, one cell per cycle
   input  logic                 mark,
   input  logic                 in_use,
   input  logic                 ml_found,
   input  logic [DIST_BITS-1:0] ml_dist,
   input  logic [IDX_BITS-1:0]  ml_idx,
   output logic                 mr_found,
   output logic [DIST_BITS-1:0] mr_dist,
   output logic [IDX_BITS-1:0]  mr_idx,
   output logic                 reached,
   output logic [IDX_BITS-1:0]  pred,
   output logic                 has_pred
);
   logic [DIST_BITS-1:0] dist_ff;
   logic                 reached_ff, done_ff, has_pred_ff;
   logic [IDX_BITS-1:0]  pred_ff;
   logic                 rv_ff, re_ff;
   logic [IDX_BITS-1:0]  rt_ff, rf_ff;
   logic [DIST_BITS-1:0] rc_ff;
   logic                 hit, take;

   assign hit  = rl_valid && rl_edge && (rl_target == IDX_BITS'(MY_INDEX));
   assign take = hit && (!reached_ff || rl_cand < dist_ff);

   // node state
   always_ff @(posedge clock) begin
      if (init) begin
         reached_ff  <= init_src;
         done_ff     <= 1'b0;
         has_pred_ff <= 1'b0;
         dist_ff     <= '0;
         pred_ff     <= '0;
      end else begin
         if (take) begin
            reached_ff  <= 1'b1;
            dist_ff     <= rl_cand;
            pred_ff     <= rl_from;
            has_pred_ff <= 1'b1;
         end
         if (mark && ml_idx == IDX_BITS'(MY_INDEX)) done_ff <= 1'b1;
      end
   end

   // forward relax command
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= rl_valid;
      rt_ff <= rl_target;
      rc_ff <= rl_cand;
      rf_ff <= rl_from;
      re_ff <= rl_edge;
   end

   assign rr_valid  = rv_ff;
   assign rr_target = rt_ff;
   assign rr_cand   = rc_ff;
   assign rr_from   = rf_ff;
   assign rr_edge   = re_ff;

   // minimum merge: strict less keeps the lower index on ties
   always_comb begin
      mr_found = ml_found;
      mr_dist  = ml_dist;
      mr_idx   = ml_idx;
      if (in_use && reached_ff && !done_ff && (!ml_found || dist_ff < ml_dist)) begin
         mr_found = 1'b1;
         mr_dist  = dist_ff;
         mr_idx   = IDX_BITS'(MY_INDEX);
      end
   end

   assign reached  = reached_ff;
   assign pred     = pred_ff;
   assign has_pred = has_pred_ff;
endmodule

/* src/dense_dijkstra_shortest_path.sv */
// ----------------------------------------------------------------------------
// dense_dijkstra_shortest_path: dense-matrix shortest path engine
// Matrix memory, node cell chain and a round sequencer.
// ----------------------------------------------------------------------------
// Load items can follow back to back. A query starts with an init state, then
// up to N rounds; each round scans the N node cells (one node cell merged into
// the running minimum per cycle), then makes the pick, then does N matrix reads
// and drains them through the relax chain; there are fewer rounds when nodes
// stay unreached. Then come the path walk and the L results of a path of L
// nodes, shown one per cycle. Results cannot be stalled by the receiver, and
// busy stays high until the last result has been shown.
module dense_dijkstra_shortest_path #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic signed [16:0] req_weight,
   input  logic [3:0]  req_start_node,
   input  logic [3:0]  req_goal_node,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_node,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import ddsp_pkg::*;

   localparam int IB = (MAX_NODES > 16) ? $clog2(MAX_NODES) : 4;
   localparam int CB = $clog2(MAX_NODES + 1);
   localparam int AB = $clog2(MAX_NODES * MAX_NODES);
   localparam int DB = WEIGHT_BITS + $clog2(MAX_NODES) + 1;
   localparam logic [WEIGHT_BITS-1:0] WMAX = '1;

   state_type state_ff, state_in;
   logic [4:0]    ncount_ff;
   logic [CB-1:0] n_eff;
   logic [IB-1:0] start_ff, goal_ff;
   logic [CB-1:0] cnt_ff;
   logic [CB-1:0] round_ff;
   logic [IB-1:0] best_ff;
   logic [IB-1:0] cur_ff;
   logic [CB-1:0] len_ff;
   logic [IB-1:0] path_mem [MAX_NODES];
   logic [IB-1:0] path_rd_ff;
   logic          emit_v_ff;
   logic          emit_last_ff;

   // matrix memory: edge bit plus weight
   logic [WEIGHT_BITS:0] mat_mem [MAX_NODES*MAX_NODES];
   logic [WEIGHT_BITS:0] mat_rd_ff;
   logic                 rd_v_ff;
   logic [IB-1:0]        rd_col_ff;
   logic [DB-1:0]        best_dist_ff;

   logic [WEIGHT_BITS:0] wr_word;
   logic                 load_we;
   always_comb begin
      wr_word = '0;
      if (!req_weight[16]) begin
         wr_word[WEIGHT_BITS] = 1'b1;
         if (17'(req_weight) > 17'(WMAX)) wr_word[WEIGHT_BITS-1:0] = WMAX;
         else wr_word[WEIGHT_BITS-1:0] = WEIGHT_BITS'(req_weight);
      end
   end
   assign load_we = start && !busy && req_mode == MODE_LOAD
                    && 32'(req_row) < MAX_NODES && 32'(req_col) < MAX_NODES;

   always_ff @(posedge clock) begin
      if (load_we)
         mat_mem[AB'(32'(req_row) * MAX_NODES + 32'(req_col))] <= wr_word;
      mat_rd_ff <= mat_mem[AB'(32'(best_ff) * MAX_NODES + 32'(cnt_ff[IB-1:0]))];
      rd_col_ff <= cnt_ff[IB-1:0];
      rd_v_ff   <= !reset && (state_ff == ST_RELAX) && cnt_ff < n_eff;
   end

   assign n_eff = (32'(ncount_ff) > MAX_NODES) ? CB'(MAX_NODES) : CB'(ncount_ff);

   // cell chain wiring
   logic              rv [MAX_NODES+1];
   logic [IB-1:0]     rt [MAX_NODES+1];
   logic [DB-1:0]     rc [MAX_NODES+1];
   logic [IB-1:0]     rf [MAX_NODES+1];
   logic              re [MAX_NODES+1];
   logic              cm_f [MAX_NODES];
   logic [DB-1:0]     cm_d [MAX_NODES];
   logic [IB-1:0]     cm_i [MAX_NODES];
   logic              c_reached [MAX_NODES];
   logic              c_haspred [MAX_NODES];
   logic [IB-1:0]     c_pred [MAX_NODES];
   logic              mf_ff;
   logic [DB-1:0]     md_ff;
   logic [IB-1:0]     mi_ff;
   logic              cell_init, scan_pick;

   assign cell_init = (state_ff == ST_INIT);
   assign rv[0] = rd_v_ff;
   assign rt[0] = rd_col_ff;
   assign rc[0] = best_dist_ff + DB'(mat_rd_ff[WEIGHT_BITS-1:0]);
   assign rf[0] = best_ff;
   assign re[0] = mat_rd_ff[WEIGHT_BITS];
   // the picked node is marked visited at the end of the scan
   assign scan_pick = (state_ff == ST_SCAN) && (cnt_ff == n_eff) && mf_ff;

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
      ddsp_cell #(.IDX_BITS(IB), .DIST_BITS(DB), .MY_INDEX(g)) u_cell (
         .clock, .reset, .init(cell_init), .init_src(start_ff == IB'(g)),
         .rl_valid(rv[g]), .rl_target(rt[g]), .rl_cand(rc[g]),
         .rl_from(rf[g]), .rl_edge(re[g]),
         .rr_valid(rv[g+1]), .rr_target(rt[g+1]), .rr_cand(rc[g+1]),
         .rr_from(rf[g+1]), .rr_edge(re[g+1]),
         .mark(scan_pick),
         .in_use(32'(g) < 32'(n_eff) && state_ff == ST_SCAN
                 && cnt_ff == CB'(g)),
         .ml_found(mf_ff), .ml_dist(md_ff), .ml_idx(mi_ff),
         .mr_found(cm_f[g]), .mr_dist(cm_d[g]), .mr_idx(cm_i[g]),
         .reached(c_reached[g]), .pred(c_pred[g]), .has_pred(c_haspred[g])
      );
   end

   // running minimum after the cell under scan
   logic                 cur_mf;
   logic [DB-1:0]        cur_md;
   logic [IB-1:0]        cur_mi;
   logic [IB-1:0]        scan_i;
   assign scan_i = cnt_ff[IB-1:0];
   assign cur_mf = cm_f[scan_i];
   assign cur_md = cm_d[scan_i];
   assign cur_mi = cm_i[scan_i];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start && !busy && req_mode == MODE_QUERY) begin
            if (n_eff == '0 || 32'(req_start_node) >= 32'(n_eff)
                || 32'(req_goal_node) >= 32'(n_eff)) state_in = ST_FAIL;
            else state_in = ST_INIT;
         end
         ST_INIT:  state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == n_eff) state_in = mf_ff ? ST_RELAX : ST_WALK;
         ST_RELAX: if (cnt_ff == n_eff + n_eff - CB'(1))
                      state_in = (round_ff + CB'(1) == n_eff) ? ST_WALK : ST_SCAN;
         ST_WALK:  if (!c_reached[goal_ff]) state_in = ST_FAIL;
                   else if (!c_haspred[cur_ff] || len_ff + CB'(1) == n_eff)
                      state_in = ST_EMIT;
         ST_EMIT:  if (len_ff == '0) state_in = ST_IDLE;
         ST_FAIL:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ncount_ff <= 5'd16;
         cnt_ff    <= '0;
         emit_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         emit_v_ff <= 1'b0;
         if (csr_valid && csr_ready) ncount_ff <= csr_data;
         unique case (state_ff)
            ST_IDLE: begin
               start_ff <= req_start_node[IB-1:0];
               goal_ff  <= req_goal_node[IB-1:0];
               cnt_ff   <= '0;
               round_ff <= '0;
               len_ff   <= '0;
               mf_ff    <= 1'b0;
            end
            ST_INIT: begin
               cnt_ff <= '0;
               mf_ff  <= 1'b0;
            end
            ST_SCAN: begin
               if (cnt_ff == n_eff) begin
                  cnt_ff       <= '0;
                  best_ff      <= mi_ff;
                  best_dist_ff <= md_ff;
                  cur_ff <= goal_ff;
               end else begin
                  cnt_ff <= cnt_ff + CB'(1);
                  mf_ff  <= cur_mf;
                  md_ff  <= cur_md;
                  mi_ff  <= cur_mi;
               end
            end
            ST_RELAX: begin
               if (state_in != ST_RELAX) begin
                  cnt_ff   <= '0;
                  mf_ff    <= 1'b0;
                  round_ff <= round_ff + CB'(1);
                  cur_ff   <= goal_ff;
               end else cnt_ff <= cnt_ff + CB'(1);
            end
            ST_WALK: begin
               if (c_reached[goal_ff]) begin
                  path_mem[len_ff[IB-1:0]] <= cur_ff;
                  len_ff <= len_ff + CB'(1);
                  cur_ff <= c_pred[cur_ff];
               end
            end
            ST_EMIT: begin
               if (len_ff != '0) begin
                  emit_v_ff    <= 1'b1;
                  path_rd_ff   <= path_mem[len_ff[IB-1:0] - IB'(1)];
                  emit_last_ff <= (len_ff == CB'(1));
                  len_ff       <= len_ff - CB'(1);
               end
            end
            ST_FAIL: begin
               emit_v_ff    <= 1'b1;
               path_rd_ff   <= '0;
               emit_last_ff <= 1'b1;
               len_ff       <= '0;
            end
            default: ;
         endcase
      end
   end

   // fail flag rides along the strobe
   logic fail_ff;
   always_ff @(posedge clock) begin
      if (reset) fail_ff <= 1'b0;
      else fail_ff <= (state_ff == ST_FAIL);
   end

   // outputs
   always_comb begin
      busy       = (state_ff != ST_IDLE) || emit_v_ff;
      csr_ready  = (state_ff == ST_IDLE);
      rsp_strobe = emit_v_ff;
      rsp_node   = 4'(path_rd_ff);
      rsp_found  = !fail_ff;
      rsp_last   = emit_last_ff;
   end
endmodule

/* src/ddsp_checker.sv */
// ----------------------------------------------------------------------------
// ddsp_checker: port-level assertions
// Checks result framing and busy behavior seen at the top level.
// ----------------------------------------------------------------------------
module ddsp_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_found,
   input logic rsp_last
);
   // results only while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while not busy");
   // a failed query gives one result, flagged last
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_last) else $error("fail not last");
   // after a last result no result follows at once
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe) else $error("result after last");
endmodule

bind dense_dijkstra_shortest_path ddsp_checker u_ddsp_checker (
   .clock, .reset, .busy, .rsp_strobe, .rsp_found, .rsp_last
);
